>>> sv/ready_queue_policy_selector_macros.svh
// Assertion macros shared by the ready queue policy selector.
// No dependencies; included by the files that carry assertions.
`ifndef READY_QUEUE_POLICY_SELECTOR_MACROS_SVH
`define READY_QUEUE_POLICY_SELECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RQPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ready queue assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RQPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ready queue assertion failed");

`endif

>>> sv/rqps_pkg.sv
// Types, codes and helpers for the ready queue policy selector.
// No dependencies; used by every module of the block.
package rqps_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_EST  = 2'd1,
        POL_LEFT = 2'd2,
        POL_PRIO = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] run_estimate;
        logic [15:0] run_left;
        logic [7:0]  prio_level;
    } t_entry;

    typedef struct packed {
        logic     pop_valid;
        t_entry   entry;
        t_status  status;
        logic [4:0] occupancy;
    } t_result;

    // Sort key of an entry under a policy; oldest-first uses a constant key.
    function automatic logic [15:0] key_of(input t_entry e, input t_policy pol);
        logic [15:0] k;
        case (pol)
            POL_EST:  k = e.run_estimate;
            POL_LEFT: k = e.run_left;
            POL_PRIO: k = {8'd0, e.prio_level};
            default:  k = 16'd0;
        endcase
        return k;
    endfunction

endpackage

>>> sv/rqps_store.sv
// Entry memory of the ready queue: one write port, one registered read port.
// Depends on rqps_pkg for the entry type.
module rqps_store #(
    parameter int DEPTH = rqps_pkg::DEPTH_DEFAULT,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  rqps_pkg::t_entry i_wdata,
    input  logic [IW-1:0]    i_raddr,
    output rqps_pkg::t_entry o_rdata
);

    rqps_pkg::t_entry r_mem [DEPTH];
    rqps_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rqps_seq.sv
// Sequencer of the ready queue: scans the store with one shared key
// comparator, then compacts it one entry a cycle. Depends on rqps_pkg.
module rqps_seq #(
    parameter int DEPTH = rqps_pkg::DEPTH_DEFAULT,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_cmd,
    input  rqps_pkg::t_entry  i_entry,
    input  rqps_pkg::t_policy i_policy,
    output logic              o_busy,
    output logic              o_strobe,
    output rqps_pkg::t_result o_res,
    output logic              o_mem_we,
    output logic [IW-1:0]     o_mem_waddr,
    output rqps_pkg::t_entry  o_mem_wdata,
    output logic [IW-1:0]     o_mem_raddr,
    input  rqps_pkg::t_entry  i_mem_rdata
);

    rqps_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_didx, n_didx;
    logic              r_dv, n_dv;
    rqps_pkg::t_entry  r_best, n_best;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic              r_strobe, n_strobe;
    rqps_pkg::t_result r_res, n_res;
    logic              take;

    function automatic logic [4:0] occ_of(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'd0, c};
        return w[4:0];
    endfunction

    // Shared comparator: the first entry seeds the minimum, later ones
    // replace it only when strictly smaller, so the oldest wins a tie.
    assign take = r_dv && ((r_didx == '0) ||
                  (rqps_pkg::key_of(i_mem_rdata, i_policy) <
                   rqps_pkg::key_of(r_best, i_policy)));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_didx      = r_didx;
        n_dv        = 1'b0;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_strobe    = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[IW-1:0];
        o_mem_wdata = i_entry;
        o_mem_raddr = r_idx[IW-1:0];
        unique case (r_state)
            rqps_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_strobe = 1'b1;
                    n_res    = '0;
                    n_res.status    = rqps_pkg::STAT_OK;
                    n_res.occupancy = occ_of(r_count);
                    if (i_cmd == rqps_pkg::CMD_PUSH) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res.status = rqps_pkg::STAT_FULL;
                        end else begin
                            o_mem_we        = 1'b1;
                            n_count         = r_count + 1'b1;
                            n_res.occupancy = occ_of(n_count);
                        end
                    end else if (r_count == '0) begin
                        n_res.status = rqps_pkg::STAT_EMPTY;
                    end else begin
                        n_strobe = 1'b0;
                        n_state  = rqps_pkg::ST_SCAN;
                        n_idx    = '0;
                    end
                end
            end
            rqps_pkg::ST_SCAN: begin
                if (take) begin
                    n_best     = i_mem_rdata;
                    n_best_idx = r_didx;
                end
                if (r_idx != r_count) begin
                    n_idx  = r_idx + 1'b1;
                    n_didx = r_idx[IW-1:0];
                    n_dv   = 1'b1;
                end else begin
                    n_state = rqps_pkg::ST_SHIFT;
                    n_idx   = CW'(n_best_idx) + 1'b1;
                end
            end
            rqps_pkg::ST_SHIFT: begin
                // Each entry behind the winner moves up one place.
                if (r_dv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_didx - 1'b1;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_idx != r_count) begin
                    n_idx  = r_idx + 1'b1;
                    n_didx = r_idx[IW-1:0];
                    n_dv   = 1'b1;
                end else begin
                    n_state         = rqps_pkg::ST_IDLE;
                    n_count         = r_count - 1'b1;
                    n_strobe        = 1'b1;
                    n_res.pop_valid = 1'b1;
                    n_res.entry     = r_best;
                    n_res.status    = rqps_pkg::STAT_OK;
                    n_res.occupancy = occ_of(n_count);
                end
            end
            default: begin
                n_state = rqps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rqps_pkg::ST_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_didx     <= n_didx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
    end

    assign o_busy   = (r_state != rqps_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

>>> sv/ready_queue_policy_selector.sv
// Top level of the ready queue policy selector: policy register, entry
// store and sequencer. Depends on rqps_pkg, rqps_store, rqps_seq and the macros.
//
//  channel   handshake                     payload
//  command   start, busy                   i_cmd, i_task_id, i_run_estimate,
//                                          i_run_left, i_prio_level
//  result    o_result_strobe (one cycle)   o_pop_valid, o_out_*, o_status,
//                                          o_occupancy
//  config    i_cfg_valid, o_cfg_ready      i_cfg_data
//
// A push, a push on a full queue and a pop on an empty queue finish in the
// cycle of transfer; their result shows in the next cycle.
// A pop scans every entry through the single store read port and comparator,
// then moves each entry behind the winner up one place to compact, and ends
// with a closing step; the result follows in the next cycle.
// busy is high throughout a pop. Reset is synchronous, active low, and
// empties the queue; the result side cannot stall.
`include "ready_queue_policy_selector_macros.svh"

module ready_queue_policy_selector #(
    parameter int DEPTH = rqps_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_run_estimate,
    input  logic [15:0] i_run_left,
    input  logic [7:0]  i_prio_level,
    output logic        o_result_strobe,
    output logic        o_pop_valid,
    output logic [15:0] o_out_task_id,
    output logic [15:0] o_out_run_estimate,
    output logic [15:0] o_out_run_left,
    output logic [7:0]  o_out_prio_level,
    output logic [1:0]  o_status,
    output logic [4:0]  o_occupancy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rqps_pkg::t_policy r_policy;
    rqps_pkg::t_entry  in_entry;
    rqps_pkg::t_result res;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;
    rqps_pkg::t_entry  mem_wdata;
    rqps_pkg::t_entry  mem_rdata;
    logic              push_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= rqps_pkg::POL_FCFS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= rqps_pkg::t_policy'(i_cfg_data);
        end
    end

    assign in_entry.task_id      = i_task_id;
    assign in_entry.run_estimate = i_run_estimate;
    assign in_entry.run_left     = i_run_left;
    assign in_entry.prio_level   = i_prio_level;

    rqps_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rqps_seq #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_entry     (in_entry),
        .i_policy    (r_policy),
        .o_busy      (busy),
        .o_strobe    (o_result_strobe),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Result fields are only meaningful while the strobe is high.
    assign o_pop_valid        = o_result_strobe & res.pop_valid;
    assign o_out_task_id      = res.entry.task_id;
    assign o_out_run_estimate = res.entry.run_estimate;
    assign o_out_run_left     = res.entry.run_left;
    assign o_out_prio_level   = res.entry.prio_level;
    assign o_status           = res.status;
    assign o_occupancy        = res.occupancy;

    assign push_take = start && !busy && (i_cmd == rqps_pkg::CMD_PUSH);

    `RQPS_ASSERT_NEXT(a_push_one_cycle, i_clk, i_rst_n, push_take, o_result_strobe && !busy)
    `RQPS_ASSERT_IMPL(a_pop_status_ok, i_clk, i_rst_n, o_pop_valid, o_status == rqps_pkg::STAT_OK)
    `RQPS_ASSERT_IMPL(a_pop_after_busy, i_clk, i_rst_n, o_pop_valid, $past(busy))

endmodule

>>> dv/ready_queue_policy_selector_test.sv
// Self-checking testbench for the ready queue policy selector: directed and random
// push/pop traffic under every pop policy, checked against a shadow queue.
// Depends on rqps_pkg and the ready_queue_policy_selector RTL.
module ready_queue_policy_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH   = rqps_pkg::DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 242;
    localparam int PRINT_CAP     = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [15:0] i_task_id = '0;
    logic [15:0] i_run_estimate = '0;
    logic [15:0] i_run_left = '0;
    logic [7:0]  i_prio_level = '0;
    logic        o_result_strobe;
    logic        o_pop_valid;
    logic [15:0] o_out_task_id;
    logic [15:0] o_out_run_estimate;
    logic [15:0] o_out_run_left;
    logic [7:0]  o_out_prio_level;
    logic [1:0]  o_status;
    logic [4:0]  o_occupancy;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;

    // Shadow copy of the queue and its policy register.
    rqps_pkg::t_entry  shadow_entries [QUEUE_DEPTH];
    int                shadow_count = 0;
    rqps_pkg::t_policy shadow_policy = rqps_pkg::POL_FCFS;

    rqps_pkg::t_result pending_results [$];
    int                error_count = 0;
    int                cycle_count = 0;

    ready_queue_policy_selector #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_task_id          (i_task_id),
        .i_run_estimate     (i_run_estimate),
        .i_run_left         (i_run_left),
        .i_prio_level       (i_prio_level),
        .o_result_strobe    (o_result_strobe),
        .o_pop_valid        (o_pop_valid),
        .o_out_task_id      (o_out_task_id),
        .o_out_run_estimate (o_out_run_estimate),
        .o_out_run_left     (o_out_run_left),
        .o_out_prio_level   (o_out_prio_level),
        .o_status           (o_status),
        .o_occupancy        (o_occupancy),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
        error_count++;
    endtask

    function automatic logic [15:0] sched_key(input rqps_pkg::t_entry e);
        logic [15:0] k;
        k = 16'd0;
        case (shadow_policy)
            rqps_pkg::POL_EST:  k = e.run_estimate;
            rqps_pkg::POL_LEFT: k = e.run_left;
            rqps_pkg::POL_PRIO: k = {8'd0, e.prio_level};
            default:            k = 16'd0;
        endcase
        return k;
    endfunction

    // Strict less-than keeps the oldest entry on a tie.
    function automatic int pick_victim();
        int best;
        int i;
        best = 0;
        if (shadow_policy != rqps_pkg::POL_FCFS) begin
            for (i = 1; i < shadow_count; i++) begin
                if (sched_key(shadow_entries[i]) < sched_key(shadow_entries[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    task automatic predict_queue_op(input rqps_pkg::t_cmd cmd, input rqps_pkg::t_entry e);
        rqps_pkg::t_result r;
        int                victim;
        int                i;
        r = '0;
        r.status = rqps_pkg::STAT_OK;
        if (cmd == rqps_pkg::CMD_PUSH) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                r.status = rqps_pkg::STAT_FULL;
            end else begin
                shadow_entries[shadow_count] = e;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.status = rqps_pkg::STAT_EMPTY;
        end else begin
            victim = pick_victim();
            r.pop_valid = 1'b1;
            r.entry = shadow_entries[victim];
            for (i = victim; i < shadow_count - 1; i++)
                shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
        end
        r.occupancy = shadow_count[4:0];
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic check_result();
        rqps_pkg::t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, occupancy", o_occupancy, 0);
        end else begin
            want = pending_results.pop_front();
            if (o_pop_valid !== want.pop_valid)
                report_mismatch("pop_valid", o_pop_valid, want.pop_valid);
            if (o_out_task_id !== want.entry.task_id)
                report_mismatch("task_id", o_out_task_id, want.entry.task_id);
            if (o_out_run_estimate !== want.entry.run_estimate)
                report_mismatch("run_estimate", o_out_run_estimate, want.entry.run_estimate);
            if (o_out_run_left !== want.entry.run_left)
                report_mismatch("run_left", o_out_run_left, want.entry.run_left);
            if (o_out_prio_level !== want.entry.prio_level)
                report_mismatch("prio_level", o_out_prio_level, want.entry.prio_level);
            if (o_status !== want.status)
                report_mismatch("status code", o_status, want.status);
            if (o_occupancy !== want.occupancy)
                report_mismatch("occupancy", o_occupancy, want.occupancy);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe === 1'b1)
            check_result();
    end

    // Holds start high until the block takes the item; start is left high so that
    // a following item can go out without a gap.
    task automatic send_item(input rqps_pkg::t_cmd cmd, input rqps_pkg::t_entry e);
        start <= 1'b1;
        i_cmd <= cmd;
        i_task_id <= e.task_id;
        i_run_estimate <= e.run_estimate;
        i_run_left <= e.run_left;
        i_prio_level <= e.prio_level;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_queue_op(cmd, e);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic await_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_policy(input rqps_pkg::t_policy pol);
        while (busy !== 1'b0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= pol;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        shadow_policy = pol;
    endtask

    // Each key field comes from a tiny range half the time so that policy keys tie often.
    function automatic rqps_pkg::t_entry random_entry();
        rqps_pkg::t_entry e;
        e.task_id = 16'($urandom);
        e.run_estimate = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        e.run_left = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        e.prio_level = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        return e;
    endfunction

    task automatic test_pop_on_empty();
        rqps_pkg::t_entry e;
        e = '1;
        send_item(rqps_pkg::CMD_POP, e);
        await_results();
    endtask

    // Each key has its minimum shared by two entries away from the head, and
    // task_id and prio_level reach both ends of their ranges.
    task automatic test_fill_and_overflow();
        rqps_pkg::t_entry e;
        int               i;
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            e.task_id = (i == 0) ? 16'h0000 :
                        (i == QUEUE_DEPTH - 1) ? 16'hffff : 16'(16'h1000 + i);
            e.run_estimate = (i == 5 || i == 9) ? 16'd3 : 16'(16'hffff - i);
            e.run_left = (i == 7 || i == 12) ? 16'd0 : 16'(16'hff00 + i);
            e.prio_level = (i == 3 || i == 14) ? 8'd0 : 8'(8'hff - i);
            send_item(rqps_pkg::CMD_PUSH, e);
        end
        e = '0;
        send_item(rqps_pkg::CMD_PUSH, e);
        await_results();
    endtask

    task automatic test_each_policy_pop();
        rqps_pkg::t_entry e;
        e = '0;
        write_policy(rqps_pkg::POL_FCFS);
        send_item(rqps_pkg::CMD_POP, e);
        await_results();
        write_policy(rqps_pkg::POL_EST);
        send_item(rqps_pkg::CMD_POP, e);
        await_results();
        write_policy(rqps_pkg::POL_LEFT);
        send_item(rqps_pkg::CMD_POP, e);
        await_results();
        write_policy(rqps_pkg::POL_PRIO);
        send_item(rqps_pkg::CMD_POP, e);
        await_results();
    endtask

    task automatic run_traffic(input int n_items, input bit with_idling);
        int             k;
        int             push_pct;
        int             quiet_left;
        rqps_pkg::t_cmd cmd;
        push_pct = 60;
        quiet_left = 0;
        for (k = 0; k < n_items; k++) begin
            // Swing between filling and draining so that both ends are hit often.
            if (shadow_count == QUEUE_DEPTH && $urandom_range(0, 3) != 0)
                push_pct = 20;
            else if (shadow_count == 0 && $urandom_range(0, 3) != 0)
                push_pct = 80;
            else if ($urandom_range(0, 30) == 0)
                push_pct = $urandom_range(20, 80);
            if (with_idling) begin
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 15) == 0)
                    quiet_left = $urandom_range(10, 40);
                else if ($urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 13));
                if ($urandom_range(0, 150) == 0)
                    await_results();
            end
            cmd = ($urandom_range(0, 99) < push_pct) ? rqps_pkg::CMD_PUSH : rqps_pkg::CMD_POP;
            send_item(cmd, random_entry());
        end
    endtask

    task automatic test_random_traffic();
        rqps_pkg::t_policy phases [6];
        int                p;
        phases[0] = rqps_pkg::POL_FCFS;
        phases[1] = rqps_pkg::POL_PRIO;
        phases[2] = rqps_pkg::POL_EST;
        phases[3] = rqps_pkg::POL_LEFT;
        phases[4] = rqps_pkg::t_policy'($urandom_range(0, 3));
        phases[5] = rqps_pkg::POL_PRIO;
        for (p = 0; p < 6; p++) begin
            write_policy(phases[p]);
            // The closing phase runs without any idling.
            run_traffic(PHASE_ITEMS, p != 5);
            await_results();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pop_on_empty();
        test_fill_and_overflow();
        test_each_policy_pop();
        test_random_traffic();
        await_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/rqps_pkg.sv
sv/rqps_store.sv
sv/rqps_seq.sv
sv/ready_queue_policy_selector.sv
dv/ready_queue_policy_selector_test.sv
